// File: sv/fnor_pkg.sv
// ============================================================================
// fnor_pkg
// Shared sizes, codes and control bundles of the outline recolouring block.
// ============================================================================
`default_nettype none

package fnor_pkg;

  // Canvas limits
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  // Derived widths
  localparam int COL_W  = $clog2(MAX_WIDTH);        // column index
  localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);    // effective width
  localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);   // input row, up to height
  localparam int OROW_W = $clog2(MAX_HEIGHT);       // output row index

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 8;

  // Register indexes of the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_OUTLINE_EN = 3'd0,
    REG_WIDTH      = 3'd1,
    REG_HEIGHT     = 3'd2,
    REG_INTERIOR   = 3'd3,
    REG_BORDER     = 3'd4
  } reg_idx_t;

  // Input request kinds
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  // Line memory access for one request
  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [COL_W-1:0] rd_col;
    logic [COL_W-1:0] wr_col;
  } mem_ctl_t;

  // Result bookkeeping for one request
  typedef struct packed {
    logic             emit;
    logic             off_edge;
    logic             last;
    logic [PIX_W-1:0] below;
  } emit_info_t;

  // Colour settings
  typedef struct packed {
    logic             outline_en;
    logic [PIX_W-1:0] interior;
    logic [PIX_W-1:0] border;
  } colour_cfg_t;

endpackage

`default_nettype wire

// File: sv/fnor_linebuf.sv
// ============================================================================
// fnor_linebuf
// Line memory holding the two latest rows per column, read one column ahead,
// plus the history registers that form the three-wide window.
// ============================================================================
`default_nettype none

module fnor_linebuf
  import fnor_pkg::*;
(
  input  wire logic                 clk,
  input  wire mem_ctl_t             ctl,
  input  wire logic [PIX_W-1:0]     pix,
  output logic      [2*PIX_W-1:0]   rd_data,   // {older row, newer row} of column ahead
  output logic      [2*PIX_W-1:0]   hist1,     // same, one request earlier
  output logic      [PIX_W-1:0]     hist2_lo   // newer row, two requests earlier
);

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_data_r;
  logic [2*PIX_W-1:0] hist1_r;
  logic [PIX_W-1:0]   hist2_r;
  logic [2*PIX_W-1:0] wr_data;
  logic               fwd;

  // Shift the column's newer value into the older half, add the new pixel
  assign wr_data = {rd_data_r[PIX_W-1:0], pix};
  // A one-column canvas reads the entry it writes in the same cycle
  assign fwd     = ctl.wr_en && (ctl.rd_col == ctl.wr_col);

  // Write the updated column
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      line_mem[ctl.wr_col] <= wr_data;
    end
  end

  // Read ahead and advance the window history
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      if (fwd) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= line_mem[ctl.rd_col];
      end
      hist1_r <= rd_data_r;
      hist2_r <= hist1_r[PIX_W-1:0];
    end
  end

  assign rd_data  = rd_data_r;
  assign hist1    = hist1_r;
  assign hist2_lo = hist2_r;

endmodule

`default_nettype wire

// File: sv/fnor_seq.sv
// ============================================================================
// fnor_seq
// Configuration registers and raster counters; decides per request whether
// it writes the line memory, reads ahead and produces a result.
// ============================================================================
`default_nettype none

module fnor_seq
  import fnor_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  accept,
  input  wire logic                  opcode,
  input  wire logic [PIX_W-1:0]      pix,
  output mem_ctl_t                   mem_ctl,
  output emit_info_t                 info,
  output colour_cfg_t                ccfg
);

  // Configuration
  logic              outline_en_r;
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic [PIX_W-1:0]  interior_r;
  logic [PIX_W-1:0]  border_r;

  // Raster position
  logic [COL_W-1:0]  in_col_r,  in_col_nxt;
  logic [ROW_W-1:0]  in_row_r,  in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;

  logic [WSZ_W-1:0]  w_eff;
  logic [ROW_W-1:0]  h_eff;
  logic              pix_ok, drain_ok, active, emit, last, off_edge;
  logic              in_col_end, out_col_end;
  logic [COL_W-1:0]  cur_col, ahead_col;
  logic              restart;

  // Clamp sizes into 1..max
  always_comb begin
    if (width_r == '0) begin
      w_eff = WSZ_W'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WSZ_W'(MAX_WIDTH);
    end else begin
      w_eff = WSZ_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = ROW_W'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(height_r);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outline_en_r <= 1'b0;
      width_r      <= SIZE_W'(8);
      height_r     <= SIZE_W'(8);
      interior_r   <= '0;
      border_r     <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_OUTLINE_EN: outline_en_r <= cfg_wdata[0];
        REG_WIDTH:      width_r      <= cfg_wdata[SIZE_W-1:0];
        REG_HEIGHT:     height_r     <= cfg_wdata[SIZE_W-1:0];
        REG_INTERIOR:   interior_r   <= cfg_wdata;
        REG_BORDER:     border_r     <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Classify the request
  assign pix_ok   = (opcode_t'(opcode) == OP_PIXEL) && (in_row_r < h_eff);
  assign drain_ok = (opcode_t'(opcode) == OP_DRAIN) && (in_row_r >= h_eff);
  assign active   = accept && (pix_ok || drain_ok);
  assign emit     = pix_ok ? (in_row_r != '0) : drain_ok;

  assign in_col_end  = (WSZ_W'(in_col_r)  == w_eff - WSZ_W'(1));
  assign out_col_end = (WSZ_W'(out_col_r) == w_eff - WSZ_W'(1));

  // Drains continue the raster one row past the frame, at the output column
  assign cur_col   = pix_ok ? in_col_r : out_col_r;
  assign ahead_col = ((WSZ_W'(cur_col) == w_eff - WSZ_W'(1))) ? '0 : cur_col + COL_W'(1);

  assign last     = out_col_end && (ROW_W'(out_row_r) == h_eff - ROW_W'(1));
  assign off_edge = (out_col_r != '0) && (WSZ_W'(out_col_r) + WSZ_W'(1) < w_eff) &&
                    (out_row_r != '0) && (ROW_W'(out_row_r) + ROW_W'(1) < h_eff);

  assign mem_ctl.rd_en  = active;
  assign mem_ctl.wr_en  = accept && pix_ok;
  assign mem_ctl.rd_col = ahead_col;
  assign mem_ctl.wr_col = in_col_r;

  assign info.emit     = active && emit;
  assign info.off_edge = off_edge;
  assign info.last     = last;
  assign info.below    = pix_ok ? pix : '0;

  assign ccfg.outline_en = outline_en_r;
  assign ccfg.interior   = interior_r;
  assign ccfg.border     = border_r;

  // Size writes and the final result restart the frame
  assign restart = (cfg_we && ((reg_idx_t'(cfg_addr) == REG_WIDTH) ||
                               (reg_idx_t'(cfg_addr) == REG_HEIGHT))) ||
                   (active && emit && last);

  // Advance the raster counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else begin
      if (accept && pix_ok) begin
        if (in_col_end) begin
          in_col_nxt = '0;
          in_row_nxt = in_row_r + ROW_W'(1);
        end else begin
          in_col_nxt = in_col_r + COL_W'(1);
        end
      end
      if (active && emit) begin
        if (out_col_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // The final result of a frame returns all counters to the start
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (active && emit && last) |=> (in_row_r == '0) && (out_row_r == '0) && (out_col_r == '0))
    else $error("frame did not restart after its final result");

  // Input never runs past the last row of the frame
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_we |-> (in_row_r <= h_eff))
    else $error("input row beyond canvas height");

  // Read-ahead and write hit the same column only on a one-column canvas
  a_fwd_only_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.wr_en && (w_eff != WSZ_W'(1))) |-> (mem_ctl.rd_col != mem_ctl.wr_col))
    else $error("read-ahead collides with write on a wide canvas");

endmodule

`default_nettype wire

// File: sv/fnor_recolour.sv
// ============================================================================
// fnor_recolour
// Window stage and output register: colours one pixel from it and its four
// neighbours and holds the result until the receiver takes it.
// ============================================================================
`default_nettype none

module fnor_recolour
  import fnor_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire emit_info_t          info,
  input  wire colour_cfg_t         ccfg,
  input  wire logic [2*PIX_W-1:0]  rd_data,
  input  wire logic [2*PIX_W-1:0]  hist1,
  input  wire logic [PIX_W-1:0]    hist2_lo,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic      [PIX_W-1:0]    out_pixel,
  output logic                     out_last,
  output logic                     take_ready
);

  // Window stage
  logic              s1_v_r, s1_v_nxt;
  logic              s1_off_edge_r;
  logic              s1_last_r;
  logic [PIX_W-1:0]  s1_below_r;

  // Output register
  logic              out_v_r, out_v_nxt;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_last_r;

  logic              move;
  logic [PIX_W-1:0]  centre, left, right, up, colour;

  assign move       = s1_v_r && (!out_v_r || out_ready);
  assign take_ready = !s1_v_r || !out_v_r || out_ready;

  // Neighbours from the line memory window
  assign centre = hist1[PIX_W-1:0];
  assign up     = hist1[2*PIX_W-1:PIX_W];
  assign left   = hist2_lo;
  assign right  = rd_data[PIX_W-1:0];

  // Pick the colour
  always_comb begin
    if (!ccfg.outline_en) begin
      colour = centre;
    end else if (s1_off_edge_r && (left != '0) && (right != '0) && (up != '0) &&
                 (s1_below_r != '0)) begin
      colour = ccfg.border;
    end else if (centre != '0) begin
      colour = ccfg.interior;
    end else begin
      colour = '0;
    end
  end

  // Stage handshake
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = info.emit;
    end else if (move) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (move) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_off_edge_r <= info.off_edge;
      s1_last_r     <= info.last;
      s1_below_r    <= info.below;
    end
    if (move) begin
      out_pix_r  <= colour;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_pixel = out_pix_r;
  assign out_last  = out_last_r;

  // A waiting window result survives a stalled output
  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ready) |=> s1_v_r)
    else $error("window result dropped while output stalled");

  // A new request never lands on a window stage that cannot drain
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!s1_v_r || move))
    else $error("request accepted over a blocked window stage");

endmodule

`default_nettype wire

// File: sv/four_neighbour_outline_recolour.sv
// ============================================================================
// four_neighbour_outline_recolour
// Outline recolouring of a raster canvas using a one-column-ahead line memory.
// ============================================================================
// Usage:
//   in_*  carries one request per beat: in_tuser[0] selects a pixel (0) or a
//         drain (1), in_tdata holds the pixel value. After each frame send
//         canvas_width drain requests to flush the last row.
//   out_* returns recoloured pixels in raster order; out_tlast marks the
//         final pixel of the canvas.
//   cfg_* writes one register per cycle; the user writes only while the block
//         is idle (not enforced); writing the width or height restarts the frame.
// Throughput: one request per cycle while out_tready is high; the line memory
//   takes one read per request and one write per pixel request.
// Result path: the request carrying the pixel one row below (or the matching
//   drain) yields the pixel's result via the window stage, then the output register.
// Reset: loads configuration defaults and clears counters and valid flags;
//   the line memory is not cleared: each entry is written in a frame before use.
// Stall: when out_tready is low the result holds in the output register, one
//   more waits in the window stage, and in_tready drops until space frees.
// ============================================================================
`default_nettype none

module four_neighbour_outline_recolour
  import fnor_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input requests
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] pixel_value
  input  wire logic [0:0]            in_tuser,   // [0] opcode
  // Results
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [7:0]            out_tdata,  // [7:0] out_pixel
  output logic                       out_tlast,  // last_pixel
  // Configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic               accept;
  logic               take_ready;
  mem_ctl_t           mem_ctl;
  emit_info_t         info;
  colour_cfg_t        ccfg;
  logic [2*PIX_W-1:0] rd_data;
  logic [2*PIX_W-1:0] hist1;
  logic [PIX_W-1:0]   hist2_lo;

  assign in_tready = take_ready;
  assign accept    = in_tvalid && take_ready;

  fnor_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .opcode    (in_tuser[0]),
    .pix       (in_tdata[PIX_W-1:0]),
    .mem_ctl   (mem_ctl),
    .info      (info),
    .ccfg      (ccfg)
  );

  fnor_linebuf u_linebuf (
    .clk      (clk),
    .ctl      (mem_ctl),
    .pix      (in_tdata[PIX_W-1:0]),
    .rd_data  (rd_data),
    .hist1    (hist1),
    .hist2_lo (hist2_lo)
  );

  fnor_recolour u_recolour (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .info       (info),
    .ccfg       (ccfg),
    .rd_data    (rd_data),
    .hist1      (hist1),
    .hist2_lo   (hist2_lo),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_pixel  (out_tdata),
    .out_last   (out_tlast),
    .take_ready (take_ready)
  );

endmodule

`default_nettype wire
